// File: src/conv3x3_relu_maxpool_layer_top_defines.svh
// Assertion macros for the conv3x3 layer RTL.
// No dependencies; define ASSERT_OFF to drop all checks.
`ifndef CONV3X3_RELU_MAXPOOL_LAYER_TOP_DEFINES_SVH
`define CONV3X3_RELU_MAXPOOL_LAYER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CRMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CRMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CRMP_ASSERT(lbl, prop, msg)
`define CRMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/crmp_pkg.sv
// Shared constants, types and arithmetic helpers of the conv3x3 layer.
// No dependencies.
package crmp_pkg;
  localparam int MAX_WIDTH   = 256;
  localparam int NUM_KERNELS = 8;
  localparam int TAPS        = 9;
  localparam int DATA_WIDTH  = 16;
  localparam int POOL_COLS   = MAX_WIDTH / 2;
  localparam int ACT_W       = 15;
  localparam int ACC_W       = 36;
  localparam int PSUM_W      = 34;

  localparam logic [1:0] FUNC_PIXEL  = 2'd0;
  localparam logic [1:0] FUNC_LOAD_W = 2'd1;
  localparam logic [1:0] FUNC_LOAD_B = 2'd2;

  typedef logic signed [DATA_WIDTH-1:0] pix_t;
  typedef pix_t win_t [TAPS];

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       emit;
    logic [6:0] pr;
    logic [6:0] pc;
  } ctl_t;

  typedef struct packed {
    logic       wr_w;
    logic       wr_b;
    logic [2:0] ksel;
    logic [3:0] tap;
    pix_t       val;
  } load_t;

  typedef struct packed {
    logic [2:0]       channel;
    logic [6:0]       pool_row;
    logic [6:0]       pool_col;
    logic [ACT_W-1:0] act;
    logic             last;
  } out_t;

  function automatic logic [ACT_W-1:0] relu_round(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = (acc + ACC_W'(128)) >>> 8;
    if (acc < 0) begin
      return '0;
    end else if (t > ACC_W'(32767)) begin
      return {ACT_W{1'b1}};
    end else begin
      return t[ACT_W-1:0];
    end
  endfunction
endpackage

// File: src/crmp_line_buf.sv
// Raster position counters, two-row line memory and 3x3 window.
// Depends on crmp_pkg.
module crmp_line_buf import crmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       take_i,
  input  logic [1:0] func_i,
  input  logic [2:0] ksel_i,
  input  logic [3:0] tap_i,
  input  pix_t       val_i,
  input  logic       fs_i,
  input  logic       cfg_we_i,
  input  logic [8:0] cfg_wdata_i,
  output win_t       win_o,
  output ctl_t       ctl_o,
  output load_t      ld_o
);
  logic [8:0] size_q, n;
  logic [7:0] row_q, col_q, r0, c0;
  logic [8:0] c1, r1;
  logic       fs;

  logic        s1_vld_q;
  logic [1:0]  s1_func_q;
  logic [2:0]  s1_ksel_q;
  logic [3:0]  s1_tap_q;
  pix_t        s1_val_q;
  logic [7:0]  s1_r_q, s1_c_q;

  logic [31:0] mem_q [MAX_WIDTH];
  logic        mvld_q [MAX_WIDTH];
  logic [31:0] rd_q, lw_data_q, lin, wdata;
  logic        rdv_q, lw_vld_q;
  logic [7:0]  lw_addr_q;
  logic        s1_pix;

  logic [7:0]  cr, cc;
  logic [8:0]  nm2, lim;
  logic        in_pool;

  win_t  win_q;
  ctl_t  ctl_q;
  load_t ld_q;

  always_comb begin
    if (size_q < 9'd3) begin
      n = 9'd3;
    end else if (size_q > 9'(MAX_WIDTH)) begin
      n = 9'(MAX_WIDTH);
    end else begin
      n = size_q;
    end
  end

  assign fs = (func_i == FUNC_PIXEL) && fs_i;
  assign r0 = fs ? 8'd0 : row_q;
  assign c0 = fs ? 8'd0 : col_q;
  assign c1 = {1'b0, c0} + 9'd1;
  assign r1 = {1'b0, r0} + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 9'(MAX_WIDTH);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (take_i && func_i == FUNC_PIXEL) begin
      if (c1 >= n) begin
        col_q <= '0;
        row_q <= (r1 >= n) ? 8'd0 : r1[7:0];
      end else begin
        col_q <= c1[7:0];
        row_q <= r0;
      end
    end
  end

  assign s1_pix = s1_vld_q && (s1_func_q == FUNC_PIXEL);
  assign lin    = (lw_vld_q && lw_addr_q == s1_c_q) ? lw_data_q :
                  (rdv_q ? rd_q : 32'd0);
  assign wdata  = {s1_val_q, lin[31:16]};

  always_ff @(posedge clk_i) begin
    if (adv_i && take_i) begin
      rd_q <= mem_q[c0];
    end
    if (adv_i && s1_pix) begin
      mem_q[s1_c_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        mvld_q[i] <= 1'b0;
      end
      rdv_q     <= 1'b0;
      lw_vld_q  <= 1'b0;
      lw_addr_q <= '0;
      lw_data_q <= '0;
    end else if (adv_i) begin
      if (take_i) begin
        rdv_q <= mvld_q[c0];
      end
      if (s1_pix) begin
        mvld_q[s1_c_q] <= 1'b1;
        lw_vld_q       <= 1'b1;
        lw_addr_q      <= s1_c_q;
        lw_data_q      <= wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && take_i) begin
      s1_func_q <= func_i;
      s1_ksel_q <= ksel_i;
      s1_tap_q  <= tap_i;
      s1_val_q  <= val_i;
      s1_r_q    <= r0;
      s1_c_q    <= c0;
    end
  end

  assign cr      = s1_r_q - 8'd2;
  assign cc      = s1_c_q - 8'd2;
  assign nm2     = n - 9'd2;
  assign lim     = {nm2[8:1], 1'b0};
  assign in_pool = s1_pix && (s1_r_q >= 8'd2) && (s1_c_q >= 8'd2) &&
                   ({1'b0, cr} < lim) && ({1'b0, cc} < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        win_q[i] <= '0;
      end
      ctl_q <= '0;
      ld_q  <= '0;
    end else if (adv_i) begin
      if (s1_pix) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i*3]   <= win_q[i*3+1];
          win_q[i*3+1] <= win_q[i*3+2];
        end
        win_q[2] <= lin[15:0];
        win_q[5] <= lin[31:16];
        win_q[8] <= s1_val_q;
      end
      ctl_q.vld   <= in_pool;
      ctl_q.first <= !cr[0] && !cc[0];
      ctl_q.emit  <= cr[0] && cc[0];
      ctl_q.pr    <= cr[7:1];
      ctl_q.pc    <= cc[7:1];
      ld_q.wr_w   <= s1_vld_q && (s1_func_q == FUNC_LOAD_W) && (int'(s1_tap_q) < TAPS) &&
                     (int'(s1_ksel_q) < NUM_KERNELS);
      ld_q.wr_b   <= s1_vld_q && (s1_func_q == FUNC_LOAD_B) &&
                     (int'(s1_ksel_q) < NUM_KERNELS);
      ld_q.ksel   <= s1_ksel_q;
      ld_q.tap    <= s1_tap_q;
      ld_q.val    <= s1_val_q;
    end
  end

  assign win_o = win_q;
  assign ctl_o = ctl_q;
  assign ld_o  = ld_q;
endmodule

// File: src/crmp_kernel_cell.sv
// One kernel cell: weights, bias, 3x3 multiply-add, ReLU and 2x2 pool store.
// Depends on crmp_pkg.
module crmp_kernel_cell import crmp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [2:0]       kid_i,
  input  load_t            ld_i,
  input  win_t             win_i,
  input  ctl_t             ctl4_i,
  input  ctl_t             ctl5_i,
  output logic [ACT_W-1:0] act_o
);
  pix_t                     w_q [TAPS];
  pix_t                     b_q, b3_q;
  logic signed [31:0]       prod_q [TAPS];
  logic signed [PSUM_W-1:0] ps_q [3];
  pix_t                     b4_q;
  logic signed [ACC_W-1:0]  acc;
  logic [ACT_W-1:0]         v_q, rd_q, lw_q, old;
  logic [6:0]               lw_pc_q;
  logic                     lw_vld_q;
  logic [ACT_W-1:0]         pool_q [POOL_COLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        w_q[i] <= '0;
      end
      b_q <= '0;
    end else if (adv_i && ld_i.ksel == kid_i) begin
      if (ld_i.wr_w) begin
        w_q[ld_i.tap] <= ld_i.val;
      end
      if (ld_i.wr_b) begin
        b_q <= ld_i.val;
      end
    end
  end

  assign acc = ACC_W'(ps_q[0]) + ACC_W'(ps_q[1]) + ACC_W'(ps_q[2]) +
               (ACC_W'(b4_q) <<< 8);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < TAPS; i++) begin
        prod_q[i] <= win_i[i] * w_q[i];
      end
      b3_q <= b_q;
      for (int i = 0; i < 3; i++) begin
        ps_q[i] <= PSUM_W'(prod_q[i*3]) + PSUM_W'(prod_q[i*3+1]) + PSUM_W'(prod_q[i*3+2]);
      end
      b4_q <= b3_q;
      v_q  <= relu_round(acc);
      rd_q <= pool_q[ctl4_i.pc];
      if (ctl5_i.vld) begin
        pool_q[ctl5_i.pc] <= act_o;
        lw_q              <= act_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_vld_q <= 1'b0;
      lw_pc_q  <= '0;
    end else if (adv_i && ctl5_i.vld) begin
      lw_vld_q <= 1'b1;
      lw_pc_q  <= ctl5_i.pc;
    end
  end

  assign old   = (lw_vld_q && lw_pc_q == ctl5_i.pc) ? lw_q : rd_q;
  assign act_o = (ctl5_i.first || v_q > old) ? v_q : old;
endmodule

// File: src/crmp_out_cell.sv
// One cell of the result chain: load a result or take the neighbor's.
// Depends on crmp_pkg.
module crmp_out_cell import crmp_pkg::*; (
  input  logic clk_i,
  input  logic load_i,
  input  logic shift_i,
  input  out_t load_data_i,
  input  out_t next_i,
  output out_t data_o
);
  out_t data_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end else if (shift_i) begin
      data_q <= next_i;
    end
  end

  assign data_o = data_q;
endmodule

// File: src/conv3x3_relu_maxpool_layer_top.sv
// Channel   Dir  Width  Content
// s_axis    in   24+3   pixel or weight/bias load beat
// m_axis    out  32+3+1 pooled activation beat, one per kernel
// cfg       in   9      image_size write
// One beat accepted per cycle unless stalled; a pixel passes s1, window, product, sum and act registers.
// A completed pool window loads 8 results into the output chain at that edge; the input
// stalls while a new window is ready and the chain holds a beat that does not leave then.
// Reset: the 256 line valid bits clear at once; no sweep.
// Depends on crmp_pkg, crmp_line_buf, crmp_kernel_cell, crmp_out_cell.
`include "conv3x3_relu_maxpool_layer_top_defines.svh"
module conv3x3_relu_maxpool_layer_top import crmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // kernel_sel, tap_sel, value, pad
  input  logic [2:0]  s_axis_tuser_i,  // func, frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // pool_row, pool_col, activation, pad
  output logic [2:0]  m_axis_tuser_o,  // channel
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i
);
  logic  adv, take, can_load, load, shift;
  win_t  win;
  ctl_t  ctl2, ctl3_q, ctl4_q, ctl5_q;
  load_t ld;
  logic [ACT_W-1:0] act [NUM_KERNELS];
  out_t  cell_in [NUM_KERNELS];
  out_t  cell_out [NUM_KERNELS+1];
  logic [3:0] cnt_q;

  assign can_load = (cnt_q == 4'd0) || (cnt_q == 4'd1 && m_axis_tready_i);
  assign adv      = !(ctl5_q.vld && ctl5_q.emit && !can_load);
  assign take     = adv && s_axis_tvalid_i;
  assign load     = adv && ctl5_q.vld && ctl5_q.emit;
  assign shift    = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = adv;

  crmp_line_buf u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .take_i      (take),
    .func_i      (s_axis_tuser_i[1:0]),
    .ksel_i      (s_axis_tdata_i[2:0]),
    .tap_i       (s_axis_tdata_i[6:3]),
    .val_i       (s_axis_tdata_i[22:7]),
    .fs_i        (s_axis_tuser_i[2]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .win_o       (win),
    .ctl_o       (ctl2),
    .ld_o        (ld)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (adv) begin
      ctl3_q <= ctl2;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  assign cell_out[NUM_KERNELS] = '0;

  for (genvar k = 0; k < NUM_KERNELS; k++) begin : g_k
    crmp_kernel_cell u_kcell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .kid_i  (3'(k)),
      .ld_i   (ld),
      .win_i  (win),
      .ctl4_i (ctl4_q),
      .ctl5_i (ctl5_q),
      .act_o  (act[k])
    );

    assign cell_in[k] = '{channel: 3'(k), pool_row: ctl5_q.pr, pool_col: ctl5_q.pc,
                          act: act[k], last: (k == NUM_KERNELS - 1)};

    crmp_out_cell u_ocell (
      .clk_i       (clk_i),
      .load_i      (load),
      .shift_i     (shift),
      .load_data_i (cell_in[k]),
      .next_i      (cell_out[k+1]),
      .data_o      (cell_out[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load) begin
      cnt_q <= 4'(NUM_KERNELS);
    end else if (shift) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 4'd0);
  assign m_axis_tdata_o  = {3'd0, cell_out[0].act, cell_out[0].pool_col,
                            cell_out[0].pool_row};
  assign m_axis_tuser_o  = cell_out[0].channel;
  assign m_axis_tlast_o  = cell_out[0].last;

  `CRMP_ASSERT(a_cnt_range, cnt_q <= 4'(NUM_KERNELS), "result count overflow")
  `CRMP_ASSERT(a_load_full, load |=> cnt_q == 4'(NUM_KERNELS), "chain not full after load")
  `CRMP_ASSERT(a_stall_hold, (ctl5_q.vld && ctl5_q.emit && !adv) |=> (ctl5_q.vld && ctl5_q.emit),
               "stalled window lost")
  `CRMP_ASSERT(a_last_chan, (m_axis_tvalid_o && m_axis_tlast_o) |->
               m_axis_tuser_o == 3'(NUM_KERNELS - 1), "last on wrong channel")
endmodule

// File: dv/tb_conv3x3_relu_maxpool_layer_top.sv
// Testbench for conv3x3_relu_maxpool_layer_top: loads, pixel frames, backpressure.
// Predicts every pooled beat in its own model of the layer; depends on crmp_pkg.
`timescale 1ns / 100ps
module tb_conv3x3_relu_maxpool_layer_top import crmp_pkg::*;;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int EXP_DEPTH = 4096;

  typedef struct {
    logic [1:0]         func;
    logic [2:0]         ksel;
    logic [3:0]         tap;
    logic signed [15:0] val;
    logic               fs;
  } layer_item_t;

  typedef struct {
    logic [2:0]  ch;
    logic [6:0]  prow;
    logic [6:0]  pcol;
    logic [14:0] act;
    logic        last;
  } pool_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_wdata_i = '0;

  conv3x3_relu_maxpool_layer_top i_dut (.*);

  always #2ns clk_i = ~clk_i;

  // predictor state
  longint     wgt_tab [NUM_KERNELS*TAPS];
  longint     bias_tab [NUM_KERNELS];
  longint     lines [2][MAX_WIDTH];
  longint     win [3][3];
  int unsigned pool_max [NUM_KERNELS][POOL_COLS];
  int unsigned row_pos, col_pos, side_cfg;
  pool_beat_t exp_beats [EXP_DEPTH];
  int         exp_wr = 0, exp_rd = 0;

  int  errors = 0;
  int  cycles = 0;
  bit  tx_idle = 1'b1, rx_idle = 1'b1;
  int  hold_req = 0;

  function automatic int unsigned conv_act(int k);
    longint acc;
    acc = bias_tab[k] * 256;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        acc += win[i][j] * wgt_tab[k*TAPS + i*3 + j];
    if (acc < 0) return 0;
    acc = (acc + 128) >>> 8;
    if (acc > 32767) acc = 32767;
    return 32'(acc);
  endfunction

  function automatic void predict_layer(layer_item_t it);
    int unsigned n, r, c, cr, cc, lim, v;
    pool_beat_t b;
    n = (side_cfg < 3) ? 3 : (side_cfg > MAX_WIDTH) ? MAX_WIDTH : side_cfg;
    if (it.func == FUNC_LOAD_W) begin
      if (it.tap < TAPS) wgt_tab[it.ksel*TAPS + it.tap] = it.val;
      return;
    end
    if (it.func == FUNC_LOAD_B) begin
      bias_tab[it.ksel] = it.val;
      return;
    end
    if (it.func != FUNC_PIXEL) return;
    if (it.fs) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = lines[0][c];
    win[1][2] = lines[1][c];
    win[2][2] = it.val;
    lines[0][c] = lines[1][c];
    lines[1][c] = it.val;
    if (r >= 2 && c >= 2) begin
      cr = r - 2;
      cc = c - 2;
      lim = ((n - 2) / 2) * 2;
      if (cr < lim && cc < lim && cc / 2 < POOL_COLS) begin
        for (int k = 0; k < NUM_KERNELS; k++) begin
          v = conv_act(k);
          if (cr[0] == 1'b0 && cc[0] == 1'b0) pool_max[k][cc/2] = v;
          else if (v > pool_max[k][cc/2]) pool_max[k][cc/2] = v;
          if (cr[0] && cc[0]) begin
            b.ch = 3'(k);
            b.prow = 7'(cr / 2);
            b.pcol = 7'(cc / 2);
            b.act = 15'(pool_max[k][cc/2]);
            b.last = (k == NUM_KERNELS - 1);
            exp_beats[exp_wr % EXP_DEPTH] = b;
            exp_wr++;
          end
        end
      end
    end
    col_pos = c + 1;
    if (col_pos >= n) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= n) row_pos = 0;
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("tb_conv3x3_relu_maxpool_layer_top NOT OK");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (exp_wr == exp_rd) begin
        report_mismatch("unexpected beat, channel", m_axis_tuser_o, -1);
      end else begin
        pool_beat_t e;
        e = exp_beats[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (m_axis_tuser_o != e.ch) report_mismatch("channel", m_axis_tuser_o, e.ch);
        if (m_axis_tdata_o[6:0] != e.prow)
          report_mismatch("pool_row", m_axis_tdata_o[6:0], e.prow);
        if (m_axis_tdata_o[13:7] != e.pcol)
          report_mismatch("pool_col", m_axis_tdata_o[13:7], e.pcol);
        if (m_axis_tdata_o[28:14] != e.act)
          report_mismatch("activation", m_axis_tdata_o[28:14], e.act);
        if (m_axis_tlast_o != e.last) report_mismatch("last", m_axis_tlast_o, e.last);
      end
    end
  end

  int rx_gap = 0, rx_hold = 0;
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      rx_hold = hold_req;
      hold_req = 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready_i <= 1'b0;
    end else if (!rx_idle) begin
      m_axis_tready_i <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 15) - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic send_item(layer_item_t it);
    int gap;
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {1'b0, it.val, it.tap, it.ksel};
    s_axis_tuser_i <= {it.fs, it.func};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_layer(it);
  endtask

  task automatic end_stream();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    end_stream();
    wait (exp_wr == exp_rd);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_size(int unsigned sz);
    drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= sz[8:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    side_cfg = sz[8:0];
    row_pos = 0;
    col_pos = 0;
  endtask

  function automatic layer_item_t make_item(logic [1:0] f, int k, int t, int v, bit fs);
    layer_item_t it;
    it.func = f;
    it.ksel = 3'(k);
    it.tap = 4'(t);
    it.val = 16'(v);
    it.fs = fs;
    return it;
  endfunction

  function automatic int rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return $urandom_range(0, 1023) - 512;
    endcase
  endfunction

  task automatic send_pixels(int count, bit first_fs);
    for (int i = 0; i < count; i++)
      send_item(make_item(FUNC_PIXEL, $urandom, $urandom, rand_value(),
                          (i == 0) ? first_fs : 1'b0));
  endtask

  task automatic load_random_kernels();
    for (int k = 0; k < NUM_KERNELS; k++) begin
      for (int t = 0; t < TAPS; t++)
        send_item(make_item(FUNC_LOAD_W, k, t, $urandom_range(0, 511) - 256,
                            1'($urandom)));
      send_item(make_item(FUNC_LOAD_B, k, $urandom, $urandom_range(0, 2047) - 1024, 0));
    end
  endtask

  task automatic test_directed();
    write_size(4);
    send_item(make_item(FUNC_LOAD_W, 0, 0, 32767, 1));
    send_item(make_item(FUNC_LOAD_W, 7, 8, -32768, 0));
    send_item(make_item(FUNC_LOAD_W, 3, 9, 1000, 0));
    send_item(make_item(FUNC_LOAD_W, 3, 15, -1, 1));
    send_item(make_item(FUNC_LOAD_B, 7, 15, 32767, 1));
    send_item(make_item(FUNC_LOAD_B, 0, 0, -32768, 0));
    send_item(make_item(FUNC_UNUSED, 7, 15, -1, 1));
    send_item(make_item(FUNC_LOAD_W, 1, 4, 256, 0));
    for (int i = 0; i < 16; i++)
      send_item(make_item(FUNC_PIXEL, 0, 0, (i % 2) ? 32767 : -32768, i == 0));
  endtask

  task automatic test_random_frames();
    int sz;
    load_random_kernels();
    for (int f = 0; f < 3; f++) begin
      sz = $urandom_range(3, 6);
      write_size(sz);
      for (int p = 0; p < sz * sz; p++) begin
        if ($urandom_range(0, 15) == 0)
          send_item(make_item(2'($urandom), $urandom, $urandom, rand_value(),
                              1'($urandom)));
        send_item(make_item(FUNC_PIXEL, $urandom, $urandom, rand_value(),
                            p == 0 || $urandom_range(0, 60) == 0));
      end
    end
  endtask

  task automatic test_backpressure();
    write_size(6);
    hold_req = 600;
    tx_idle = 1'b0;
    send_pixels(36, 1'b1);
    tx_idle = 1'b1;
    drain();
  endtask

  task automatic test_size_extremes();
    write_size(0);
    send_pixels(12, 1'b1);
    write_size(3);
    send_pixels(9, 1'b1);
    write_size(511);
    send_pixels(258, 1'b1);
  endtask

  task automatic test_no_idle();
    write_size(6);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_pixels(36, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < NUM_KERNELS*TAPS; i++) wgt_tab[i] = 0;
    for (int i = 0; i < NUM_KERNELS; i++) bias_tab[i] = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      lines[0][i] = 0;
      lines[1][i] = 0;
    end
    for (int i = 0; i < 9; i++) win[i/3][i%3] = 0;
    row_pos = 0;
    col_pos = 0;
    side_cfg = 256;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_frames();
    test_backpressure();
    test_size_extremes();
    test_no_idle();
    end_stream();
    wait (exp_wr == exp_rd);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && exp_wr == exp_rd) begin
      $display("tb_conv3x3_relu_maxpool_layer_top OK");
    end else begin
      $display("tb_conv3x3_relu_maxpool_layer_top NOT OK");
    end
    $finish;
  end
endmodule
